// ===== sv/yuyv_to_rgb_framebuffer_writer_assert.svh =====
// Assertion macros for the YUYV to RGB framebuffer writer.
`ifndef YUYV_TO_RGB_FRAMEBUFFER_WRITER_ASSERT_SVH
`define YUYV_TO_RGB_FRAMEBUFFER_WRITER_ASSERT_SVH

// The property must hold in the same cycle as the condition.
`define YRFW_ASSERT_NOW(label, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
    else $error(msg);

// The property must hold in the cycle after the condition.
`define YRFW_ASSERT_NEXT(label, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
    else $error(msg);

`endif

// ===== sv/yrfw_pkg.sv =====
// Types, constants and functions shared by the framebuffer writer modules.
package yrfw_pkg;

  localparam int MAX_ROW_PIXELS = 2048;
  localparam int MAX_ROWS       = 2048;

  localparam int PAIR_MAX = MAX_ROW_PIXELS / 2;
  localparam int COL_W    = $clog2(PAIR_MAX);
  localparam int ROW_W    = $clog2(MAX_ROWS);

  localparam int SCOL_W = 12;
  localparam int SROW_W = 12;
  localparam int BPP_W  = 3;
  localparam int LB_W   = 16;
  localparam int PPR_W  = 11;
  localparam int RPF_W  = 12;
  localparam int ADDR_W = 28;
  localparam int PIX_W  = 32;
  localparam int CFG_DATA_W = 16;
  localparam int CFG_IDX_W  = 3;

  localparam int CCMP_W = (COL_W + 1 > PPR_W) ? COL_W + 1 : PPR_W;
  localparam int RCMP_W = (ROW_W + 1 > RPF_W) ? ROW_W + 1 : RPF_W;
  localparam int X_W    = ((COL_W + 1 > SCOL_W) ? COL_W + 1 : SCOL_W) + 1;
  localparam int Y_W    = ((ROW_W > SROW_W) ? ROW_W : SROW_W) + 1;

  localparam int LUMA_W = 17;
  localparam int SUM_W  = 20;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [SCOL_W-1:0] START_COLUMN_RST = SCOL_W'(10);
  localparam logic [SROW_W-1:0] START_ROW_RST    = SROW_W'(10);
  localparam logic [BPP_W-1:0]  BPP_RST          = BPP_W'(2);
  localparam logic [LB_W-1:0]   LINE_BYTES_RST   = LB_W'(640);
  localparam logic [PPR_W-1:0]  PPR_RST          = PPR_W'(160);
  localparam logic [RPF_W-1:0]  RPF_RST          = RPF_W'(240);

  localparam logic [CCMP_W-1:0] PAIR_LIMIT = CCMP_W'(PAIR_MAX);
  localparam logic [RCMP_W-1:0] ROW_LIMIT  = RCMP_W'(MAX_ROWS);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_START_COLUMN    = 3'd0,
    CFG_START_ROW       = 3'd1,
    CFG_BYTES_PER_PIXEL = 3'd2,
    CFG_LINE_BYTES      = 3'd3,
    CFG_PAIRS_PER_ROW   = 3'd4,
    CFG_ROWS_PER_FRAME  = 3'd5,
    CFG_PIXEL_FORMAT    = 3'd6
  } cfg_idx_t;

  typedef enum logic {
    FMT_RGB565   = 1'b0,
    FMT_XRGB8888 = 1'b1
  } pix_fmt_t;

  typedef struct packed {
    logic [7:0] luma_first;
    logic [7:0] chroma_blue;
    logic [7:0] luma_second;
    logic [7:0] chroma_red;
  } in_t;

  typedef struct packed {
    logic [ADDR_W-1:0] pixel_address;
    logic [PIX_W-1:0]  first_pixel;
    logic [PIX_W-1:0]  second_pixel;
    logic              row_end;
    logic              frame_end;
  } out_t;

  typedef struct packed {
    logic [SCOL_W-1:0] start_column;
    logic [SROW_W-1:0] start_row;
    logic [BPP_W-1:0]  bytes_per_pixel;
    logic [LB_W-1:0]   line_bytes;
    logic [PPR_W-1:0]  pairs_per_row;
    logic [RPF_W-1:0]  rows_per_frame;
    pix_fmt_t          pixel_format;
  } cfg_t;

  typedef struct packed {
    in_t            pix;
    logic [X_W-1:0] x;
    logic [Y_W-1:0] y;
    logic           row_end;
    logic           frame_end;
  } job_t;

  typedef struct packed {
    logic              full;
    logic              empty;
    logic [QCNT_W-1:0] count;
  } q_stat_t;

  function automatic logic signed [SUM_W-1:0] cmul(input logic signed [8:0] v,
                                                   input logic signed [11:0] k);
    logic signed [SUM_W:0] p;
    p = v * k;
    return signed'(p[SUM_W-1:0]);
  endfunction

  function automatic logic [7:0] clip_channel(input logic signed [SUM_W-1:0] s);
    logic signed [SUM_W-1:0] v;
    v = s >>> 8;
    if (v < 0) begin
      return 8'd0;
    end else if (v > 255) begin
      return 8'd255;
    end
    return v[7:0];
  endfunction

  function automatic logic [PIX_W-1:0] pack_pixel(input pix_fmt_t fmt,
                                                  input logic [7:0] r,
                                                  input logic [7:0] g,
                                                  input logic [7:0] b);
    if (fmt == FMT_XRGB8888) begin
      return {8'hff, r, g, b};
    end
    return {16'd0, r[7:3], g[7:2], b[7:3]};
  endfunction

endpackage

// ===== sv/yuyv_to_rgb_framebuffer_writer.sv =====
// Top level of the YUYV to RGB framebuffer writer with its configuration registers.
//
//   Port group  Direction  Payload
//   in_*        input      in_t: luma_first, chroma_blue, luma_second, chroma_red
//   out_*       output     out_t: pixel_address, first_pixel, second_pixel, flags
//   cfg_*       input      register index and 16-bit write data
//
// One macropixel per cycle is accepted while the queue has room and one result per cycle
// is delivered while out_ready is high and a result is waiting.
// The latency is the queue entry plus the multiply register ahead of the clip output register.
// Reset clears the counters, the queue and the pipeline and loads the register defaults.
// An output stall freezes the pipeline; the queue absorbs input until it is full.
module yuyv_to_rgb_framebuffer_writer (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  yrfw_pkg::in_t                      in_data,
  output logic                               out_valid,
  input  logic                               out_ready,
  output yrfw_pkg::out_t                     out_data,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [yrfw_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [yrfw_pkg::CFG_DATA_W-1:0]    cfg_data
);
  import yrfw_pkg::*;

`include "yuyv_to_rgb_framebuffer_writer_assert.svh"

  cfg_t    cfg_r, cfg_nxt;
  q_stat_t q_stat;
  job_t    push_data, pop_data;
  logic    push, pop;

  assign cfg_ready = 1'b1;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      case (cfg_idx_t'(cfg_index))
        CFG_START_COLUMN:    cfg_nxt.start_column    = cfg_data[SCOL_W-1:0];
        CFG_START_ROW:       cfg_nxt.start_row       = cfg_data[SROW_W-1:0];
        CFG_BYTES_PER_PIXEL: cfg_nxt.bytes_per_pixel = cfg_data[BPP_W-1:0];
        CFG_LINE_BYTES:      cfg_nxt.line_bytes      = cfg_data[LB_W-1:0];
        CFG_PAIRS_PER_ROW:   cfg_nxt.pairs_per_row   = cfg_data[PPR_W-1:0];
        CFG_ROWS_PER_FRAME:  cfg_nxt.rows_per_frame  = cfg_data[RPF_W-1:0];
        CFG_PIXEL_FORMAT:    cfg_nxt.pixel_format    = pix_fmt_t'(cfg_data[0]);
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.start_column    <= START_COLUMN_RST;
      cfg_r.start_row       <= START_ROW_RST;
      cfg_r.bytes_per_pixel <= BPP_RST;
      cfg_r.line_bytes      <= LINE_BYTES_RST;
      cfg_r.pairs_per_row   <= PPR_RST;
      cfg_r.rows_per_frame  <= RPF_RST;
      cfg_r.pixel_format    <= FMT_RGB565;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  yrfw_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .cfg       (cfg_r),
    .q_stat    (q_stat),
    .push      (push),
    .push_data (push_data)
  );

  yrfw_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .pop_data  (pop_data),
    .q_stat    (q_stat)
  );

  yrfw_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .q_stat    (q_stat),
    .job       (pop_data),
    .pop       (pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  `YRFW_ASSERT_NEXT(a_queue_fill, push && !pop, q_stat.count == $past(q_stat.count) + 1, "queue count did not grow on a lone push")
  `YRFW_ASSERT_NOW(a_stall_only_full, !in_ready, q_stat.count == QCNT_W'(QUEUE_DEPTH), "input stalled with room in the queue")
  `YRFW_ASSERT_NOW(a_frame_in_row, out_valid && out_data.frame_end, out_data.row_end, "frame end without row end")

endmodule

// ===== sv/yrfw_front.sv =====
// Front end: accepts macropixels, tracks column and row, and flags line and frame ends.
module yrfw_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  yrfw_pkg::in_t       in_data,
  input  yrfw_pkg::cfg_t      cfg,
  input  yrfw_pkg::q_stat_t   q_stat,
  output logic                push,
  output yrfw_pkg::job_t      push_data
);
  import yrfw_pkg::*;

  logic [COL_W-1:0]  col_r, col_nxt;
  logic [ROW_W-1:0]  row_r, row_nxt;
  logic [CCMP_W-1:0] col_inc, ppr_eff, ppr_ext;
  logic [RCMP_W-1:0] row_inc, rpf_eff, rpf_ext;
  logic              row_end, frame_end;

  assign in_ready = !q_stat.full;
  assign push     = in_valid && in_ready;

  always_comb begin
    ppr_ext   = CCMP_W'(cfg.pairs_per_row);
    rpf_ext   = RCMP_W'(cfg.rows_per_frame);
    ppr_eff   = (ppr_ext > PAIR_LIMIT) ? PAIR_LIMIT : ppr_ext;
    rpf_eff   = (rpf_ext > ROW_LIMIT) ? ROW_LIMIT : rpf_ext;
    col_inc   = CCMP_W'(col_r) + CCMP_W'(1);
    row_inc   = RCMP_W'(row_r) + RCMP_W'(1);
    row_end   = col_inc >= ppr_eff;
    frame_end = row_end && (row_inc >= rpf_eff);

    push_data.pix       = in_data;
    push_data.x         = X_W'(cfg.start_column) + X_W'({col_r, 1'b0});
    push_data.y         = Y_W'(cfg.start_row) + Y_W'(row_r);
    push_data.row_end   = row_end;
    push_data.frame_end = frame_end;

    col_nxt = col_r;
    row_nxt = row_r;
    if (push) begin
      if (row_end) begin
        col_nxt = '0;
        row_nxt = frame_end ? '0 : row_inc[ROW_W-1:0];
      end else begin
        col_nxt = col_inc[COL_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

endmodule

// ===== sv/yrfw_queue.sv =====
// Short queue between the front end and the conversion pipeline.
module yrfw_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  yrfw_pkg::job_t     push_data,
  input  logic               pop,
  output yrfw_pkg::job_t     pop_data,
  output yrfw_pkg::q_stat_t  q_stat
);
  import yrfw_pkg::*;

  job_t              mem_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] count_r, count_nxt;

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + QPTR_W'(1) : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + QPTR_W'(1) : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !pop) begin
      count_nxt = count_r + QCNT_W'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - QCNT_W'(1);
    end
    q_stat.full  = count_r == QCNT_W'(QUEUE_DEPTH);
    q_stat.empty = count_r == '0;
    q_stat.count = count_r;
  end

  assign pop_data = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

// ===== sv/yrfw_back.sv =====
// Back end: two-stage color conversion, pixel packing and address calculation.
module yrfw_back (
  input  logic               clk,
  input  logic               rst_n,
  input  yrfw_pkg::cfg_t     cfg,
  input  yrfw_pkg::q_stat_t  q_stat,
  input  yrfw_pkg::job_t     job,
  output logic               pop,
  output logic               out_valid,
  input  logic               out_ready,
  output yrfw_pkg::out_t     out_data
);
  import yrfw_pkg::*;

  logic                    adv;
  logic                    s1_valid_r;
  logic [LUMA_W-1:0]       yy0_r, yy1_r;
  logic signed [SUM_W-1:0] re_r, gd_r, ge_r, bd_r;
  logic [ADDR_W-1:0]       px_r, py_r;
  logic                    s1_row_end_r, s1_frame_end_r;
  logic signed [8:0]       d, e;
  logic signed [SUM_W-1:0] y0s, y1s;
  logic [7:0]              r0, g0, b0, r1, g1, b1;
  logic                    out_valid_r;
  out_t                    out_r, out_nxt;

  assign adv       = !out_valid_r || out_ready;
  assign pop       = adv && !q_stat.empty;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;
  assign d         = signed'({{2{~job.pix.chroma_blue[7]}}, job.pix.chroma_blue[6:0]});
  assign e         = signed'({{2{~job.pix.chroma_red[7]}}, job.pix.chroma_red[6:0]});

  always_ff @(posedge clk) begin
    if (adv) begin
      yy0_r          <= LUMA_W'(job.pix.luma_first) * LUMA_W'(298);
      yy1_r          <= LUMA_W'(job.pix.luma_second) * LUMA_W'(298);
      re_r           <= cmul(e, 12'sd409);
      gd_r           <= cmul(d, 12'sd100);
      ge_r           <= cmul(e, 12'sd208);
      bd_r           <= cmul(d, 12'sd516);
      px_r           <= ADDR_W'(job.x * cfg.bytes_per_pixel);
      py_r           <= ADDR_W'(job.y * cfg.line_bytes);
      s1_row_end_r   <= job.row_end;
      s1_frame_end_r <= job.frame_end;
    end
  end

  always_comb begin
    y0s = signed'(SUM_W'(yy0_r));
    y1s = signed'(SUM_W'(yy1_r));
    r0  = clip_channel(y0s + re_r + SUM_W'(128));
    g0  = clip_channel(y0s - gd_r - ge_r + SUM_W'(128));
    b0  = clip_channel(y0s + bd_r + SUM_W'(128));
    r1  = clip_channel(y1s + re_r + SUM_W'(128));
    g1  = clip_channel(y1s - gd_r - ge_r + SUM_W'(128));
    b1  = clip_channel(y1s + bd_r + SUM_W'(128));
    out_nxt.pixel_address = px_r + py_r;
    out_nxt.first_pixel   = pack_pixel(cfg.pixel_format, r0, g0, b0);
    out_nxt.second_pixel  = pack_pixel(cfg.pixel_format, r1, g1, b1);
    out_nxt.row_end       = s1_row_end_r;
    out_nxt.frame_end     = s1_frame_end_r;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_r <= out_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      s1_valid_r  <= pop;
      out_valid_r <= s1_valid_r;
    end
  end

endmodule
